// File: rtl/textured_wall_column_mapper_macros.svh
`ifndef TEXTURED_WALL_COLUMN_MAPPER_MACROS_SVH
`define TEXTURED_WALL_COLUMN_MAPPER_MACROS_SVH

// Antecedent holds -> consequent holds in the same cycle.
`define TWCM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds -> consequent holds in the next cycle.
`define TWCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Invariant.
`define TWCM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// File: rtl/twcm_pkg.sv
`default_nettype none

package twcm_pkg;

  localparam int unsigned DEF_MAX_IMAGE_HEIGHT = 64;
  localparam int unsigned DEF_MAX_TEXTURE_SIZE = 256;

  localparam int unsigned IH_W       = 7;
  localparam int unsigned TW_W       = 9;
  localparam int unsigned TH_W       = 9;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_ADDR_W = 2;

  localparam int unsigned COL_W  = 8;
  localparam int unsigned LH_W   = 12;
  localparam int unsigned SGN_W  = 2;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned ROW_W  = 6;
  localparam int unsigned TEX_W  = 8;
  localparam int unsigned SEL_W  = 2;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned STEP_W    = TH_W + FRAC_BITS;
  localparam int unsigned OFS_W     = LH_W - 1;
  localparam int unsigned POS_W     = OFS_W + STEP_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(STEP_W + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_HEIGHT   = 2'd0,
    REG_TEXTURE_WIDTH  = 2'd1,
    REG_TEXTURE_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [SGN_W-1:0] {
    SIGN_NEG  = 2'd0,
    SIGN_ZERO = 2'd1,
    SIGN_POS  = 2'd2
  } sign_e;

  typedef enum logic [SEL_W-1:0] {
    TEX_WEST  = 2'd0,
    TEX_EAST  = 2'd1,
    TEX_NORTH = 2'd2,
    TEX_SOUTH = 2'd3
  } tex_sel_e;

  typedef struct packed {
    logic [COL_W-1:0]  column_x;
    logic [LH_W-1:0]   line_height;
    logic              hit_side;
    logic [SGN_W-1:0]  dir_x_sign;
    logic [SGN_W-1:0]  dir_y_sign;
    logic [FRAC_W-1:0] wall_frac;
  } in_beat_t;

  typedef struct packed {
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] row_y;
    logic [SEL_W-1:0] texture_select;
    logic [TEX_W-1:0] texel_x;
    logic [TEX_W-1:0] texel_y;
    logic             last;
  } out_beat_t;

  typedef struct packed {
    logic [SEL_W-1:0] sel;
    logic [TEX_W-1:0] texel_x;
    logic [ROW_W-1:0] start_row;
    logic [ROW_W-1:0] end_row;
    logic [OFS_W-1:0] offset;
    logic [LH_W-1:0]  line_height;
    logic [TH_W-1:0]  tex_h;
  } geom_t;

endpackage

`default_nettype wire

// File: rtl/twcm_geom.sv
`default_nettype none

module twcm_geom #(
  parameter int unsigned MAX_IMAGE_HEIGHT = twcm_pkg::DEF_MAX_IMAGE_HEIGHT,
  parameter int unsigned MAX_TEXTURE_SIZE = twcm_pkg::DEF_MAX_TEXTURE_SIZE
) (
  input  twcm_pkg::in_beat_t               in_i,
  input  logic [twcm_pkg::IH_W-1:0]        image_height_i,
  input  logic [twcm_pkg::TW_W-1:0]        texture_width_i,
  input  logic [twcm_pkg::TH_W-1:0]        texture_height_i,
  output twcm_pkg::geom_t                  geom_o
);
  import twcm_pkg::*;

  logic [IH_W-1:0]          ih, ih_m1;
  logic [TW_W-1:0]          tw, tx_raw, tx_mir;
  logic [TH_W-1:0]          th;
  logic [LH_W-1:0]          lh;
  logic [ROW_W-1:0]         hh;
  logic [OFS_W-1:0]         hl;
  logic [LH_W-1:0]          span_sum;
  logic [FRAC_W+TW_W-1:0]   tx_prod;
  logic                     hh_gt, xpos, xneg, ypos, yneg, mirror;
  tex_sel_e                 sel;

  always_comb begin
    if (image_height_i == '0) begin
      ih = IH_W'(1);
    end else if (image_height_i > IH_W'(MAX_IMAGE_HEIGHT)) begin
      ih = IH_W'(MAX_IMAGE_HEIGHT);
    end else begin
      ih = image_height_i;
    end
    if (texture_width_i == '0) begin
      tw = TW_W'(1);
    end else if (texture_width_i > TW_W'(MAX_TEXTURE_SIZE)) begin
      tw = TW_W'(MAX_TEXTURE_SIZE);
    end else begin
      tw = texture_width_i;
    end
    if (texture_height_i == '0) begin
      th = TH_W'(1);
    end else if (texture_height_i > TH_W'(MAX_TEXTURE_SIZE)) begin
      th = TH_W'(MAX_TEXTURE_SIZE);
    end else begin
      th = texture_height_i;
    end
  end

  assign lh = (in_i.line_height == '0) ? LH_W'(1) : in_i.line_height;

  // sign code 3 counts as positive
  assign xpos = (in_i.dir_x_sign != SIGN_NEG) && (in_i.dir_x_sign != SIGN_ZERO);
  assign xneg = (in_i.dir_x_sign == SIGN_NEG);
  assign ypos = (in_i.dir_y_sign != SIGN_NEG) && (in_i.dir_y_sign != SIGN_ZERO);
  assign yneg = (in_i.dir_y_sign == SIGN_NEG);

  always_comb begin
    priority if (!in_i.hit_side && xpos) begin
      sel = TEX_WEST;
    end else if (!in_i.hit_side && xneg) begin
      sel = TEX_EAST;
    end else if (in_i.hit_side && ypos) begin
      sel = TEX_NORTH;
    end else begin
      sel = TEX_SOUTH;
    end
  end

  assign geom_o.sel = sel;

  assign mirror  = (!in_i.hit_side && xpos) || (in_i.hit_side && yneg);
  assign tx_prod = in_i.wall_frac * tw;
  assign tx_raw  = tx_prod[FRAC_W+TW_W-1:FRAC_W];
  assign tx_mir  = tw - tx_raw - TW_W'(1);
  assign geom_o.texel_x = mirror ? tx_mir[TEX_W-1:0] : tx_raw[TEX_W-1:0];

  assign hh       = ih[IH_W-1:1];
  assign hl       = lh[LH_W-1:1];
  assign hh_gt    = {{(OFS_W-ROW_W){1'b0}}, hh} > hl;
  assign span_sum = {{(LH_W-ROW_W){1'b0}}, hh} + {1'b0, hl};
  assign ih_m1    = ih - IH_W'(1);

  assign geom_o.start_row = hh_gt ? (hh - hl[ROW_W-1:0]) : '0;
  assign geom_o.offset    = hh_gt ? '0 : (hl - {{(OFS_W-ROW_W){1'b0}}, hh});
  assign geom_o.end_row   = (span_sum >= {{(LH_W-IH_W){1'b0}}, ih}) ? ih_m1[ROW_W-1:0]
                                                                      : span_sum[ROW_W-1:0];
  assign geom_o.line_height = lh;
  assign geom_o.tex_h       = th;

endmodule

`default_nettype wire

// File: rtl/twcm_div.sv
`default_nettype none

module twcm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [twcm_pkg::TH_W-1:0]     tex_h_i,
  input  logic [twcm_pkg::LH_W-1:0]     divisor_i,
  output logic                          busy_o,
  output logic [twcm_pkg::STEP_W-1:0]   quot_o
);
  import twcm_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [LH_W-1:0]      rem_q, rem_d, div_q;
  logic [STEP_W-1:0]    dq_q, dq_d;
  logic [LH_W:0]        trial;
  logic [LH_W+1:0]      diff;
  logic                 fits;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem_q, dq_q[STEP_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, div_q};
  assign fits  = !diff[LH_W+1];

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dq_d  = dq_q;
    if (start_i) begin
      cnt_d = DIV_CNT_W'(STEP_W);
      rem_d = '0;
      dq_d  = {tex_h_i, {FRAC_BITS{1'b0}}};
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - DIV_CNT_W'(1);
      rem_d = fits ? diff[LH_W-1:0] : trial[LH_W-1:0];
      dq_d  = {dq_q[STEP_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = dq_q;

endmodule

`default_nettype wire

// File: rtl/textured_wall_column_mapper.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_ready_o | in_data_i (in_beat_t), one column
// out     | output    | out_valid_o/out_ready_i | out_data_o (out_beat_t), one row
// cfg     | input     | cfg_we_i, no wait       | cfg_addr_i, cfg_wdata_i
//
// Each column is an accept, the bit-serial step divider (25 quotient bits and the
// hand-off), the start-offset multiply, then one row beat per cycle while
// out_ready_i is high, for the rows drawn (1..64). in_ready_o is high only between
// columns; a pending last beat does not block it. A stall on out_ready_i holds the
// row sequencer.
// Reset clears control state and loads the register reset values; no clearing pass.
`default_nettype none

module textured_wall_column_mapper #(
  parameter int unsigned MAX_IMAGE_HEIGHT = twcm_pkg::DEF_MAX_IMAGE_HEIGHT,
  parameter int unsigned MAX_TEXTURE_SIZE = twcm_pkg::DEF_MAX_TEXTURE_SIZE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  twcm_pkg::in_beat_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output twcm_pkg::out_beat_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [twcm_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [twcm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import twcm_pkg::*;
  `include "textured_wall_column_mapper_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [IH_W-1:0]        ih_reg_q;
  logic [TW_W-1:0]        tw_reg_q;
  logic [TH_W-1:0]        th_reg_q;
  geom_t                  geom, geom_q;
  logic [COL_W-1:0]       col_q;
  logic [ROW_W-1:0]       y_q;
  logic [POS_W-1:0]       pos_q;
  logic [STEP_W-1:0]      step_q, quot;
  logic [OFS_W+STEP_W-1:0] ofs_prod;
  logic [POS_W-FRAC_BITS-1:0] ty_full;
  logic [TH_W-1:0]        ty;
  logic                   div_busy, accept, load, last_row;
  logic                   out_valid_q;
  out_beat_t              out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ih_reg_q <= IH_W'(64);
      tw_reg_q <= TW_W'(64);
      th_reg_q <= TH_W'(64);
    end else if (cfg_we_i) begin
      if (cfg_addr_i == REG_IMAGE_HEIGHT) begin
        ih_reg_q <= cfg_wdata_i[IH_W-1:0];
      end
      if (cfg_addr_i == REG_TEXTURE_WIDTH) begin
        tw_reg_q <= cfg_wdata_i[TW_W-1:0];
      end
      if (cfg_addr_i == REG_TEXTURE_HEIGHT) begin
        th_reg_q <= cfg_wdata_i[TH_W-1:0];
      end
    end
  end

  twcm_geom #(
    .MAX_IMAGE_HEIGHT (MAX_IMAGE_HEIGHT),
    .MAX_TEXTURE_SIZE (MAX_TEXTURE_SIZE)
  ) u_geom (
    .in_i             (in_data_i),
    .image_height_i   (ih_reg_q),
    .texture_width_i  (tw_reg_q),
    .texture_height_i (th_reg_q),
    .geom_o           (geom)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  twcm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .tex_h_i   (geom.tex_h),
    .divisor_i (geom.line_height),
    .busy_o    (div_busy),
    .quot_o    (quot)
  );

  assign ofs_prod = geom_q.offset * step_q;

  assign ty_full  = pos_q[POS_W-1:FRAC_BITS];
  assign ty       = (ty_full >= (POS_W-FRAC_BITS)'(geom_q.tex_h))
                    ? (geom_q.tex_h - TH_W'(1)) : ty_full[TH_W-1:0];
  assign last_row = (y_q == geom_q.end_row);
  assign load     = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_DIV;
      S_DIV:  if (!div_busy) state_d = S_MUL;
      S_MUL:  state_d = S_EMIT;
      S_EMIT: if (load && last_row) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      geom_q <= geom;
      col_q  <= in_data_i.column_x;
    end
    if ((state_q == S_DIV) && !div_busy) begin
      step_q <= quot;
    end
    if (state_q == S_MUL) begin
      pos_q <= {1'b0, ofs_prod};
      y_q   <= geom_q.start_row;
    end else if (load) begin
      pos_q <= pos_q + {{(POS_W-STEP_W){1'b0}}, step_q};
      y_q   <= y_q + ROW_W'(1);
    end
    if (load) begin
      out_q.out_column     <= col_q;
      out_q.row_y          <= y_q;
      out_q.texture_select <= geom_q.sel;
      out_q.texel_x        <= geom_q.texel_x;
      out_q.texel_y        <= ty[TEX_W-1:0];
      out_q.last           <= last_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TWCM_ASSERT_ALWAYS(a_state_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `TWCM_ASSERT_NEXT(a_accept_div, clk_i, rst_ni, accept, (state_q == S_DIV) && div_busy,
                    "divider not started on accept")
  `TWCM_ASSERT_IMP(a_row_in_span, clk_i, rst_ni, state_q == S_EMIT,
                   (y_q >= geom_q.start_row) && (y_q <= geom_q.end_row), "row left the span")
  `TWCM_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, load && last_row,
                    (state_q == S_IDLE) && out_valid_q && out_q.last, "last beat not closing")

endmodule

`default_nettype wire

// File: dv/textured_wall_column_checker.sv
module textured_wall_column_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  twcm_pkg::in_beat_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  twcm_pkg::out_beat_t             out_data_i,
  input  logic                            cfg_we_i,
  input  logic [twcm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [twcm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_rows_o
);
  import twcm_pkg::*;

  logic [IH_W-1:0] image_height_q;
  logic [TW_W-1:0] texture_width_q;
  logic [TH_W-1:0] texture_height_q;
  out_beat_t       row_q[$];

  function automatic longint unsigned fit_reg(longint unsigned v, longint unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Queue every row beat one column produces, top row first.
  function automatic void plan_column(in_beat_t b);
    longint unsigned ih, tw, th, lh, half_img, half_line;
    longint unsigned start_row, end_row, tx, step, acc, ty;
    logic            x_pos, x_neg, y_pos, y_neg, mirror;
    tex_sel_e        sel;
    out_beat_t       r;
    ih = fit_reg(64'(image_height_q), 64'(DEF_MAX_IMAGE_HEIGHT));
    tw = fit_reg(64'(texture_width_q), 64'(DEF_MAX_TEXTURE_SIZE));
    th = fit_reg(64'(texture_height_q), 64'(DEF_MAX_TEXTURE_SIZE));
    // the unused sign code counts as positive
    x_neg = (b.dir_x_sign == SIGN_NEG);
    x_pos = !(x_neg || b.dir_x_sign == SIGN_ZERO);
    y_neg = (b.dir_y_sign == SIGN_NEG);
    y_pos = !(y_neg || b.dir_y_sign == SIGN_ZERO);
    if (!b.hit_side && x_pos) sel = TEX_WEST;
    else if (!b.hit_side && x_neg) sel = TEX_EAST;
    else if (b.hit_side && y_pos) sel = TEX_NORTH;
    else sel = TEX_SOUTH;
    lh = 64'(b.line_height);
    if (lh == 0) lh = 1;
    half_img  = ih / 2;
    half_line = lh / 2;
    start_row = (half_img > half_line) ? half_img - half_line : 0;
    end_row   = half_img + half_line;
    if (end_row >= ih) end_row = ih - 1;
    tx = 64'(b.wall_frac);
    tx = (tx * tw) >> 16;
    mirror = (!b.hit_side && x_pos) || (b.hit_side && y_neg);
    if (mirror) tx = tw - tx - 1;
    step = (th << 16) / lh;
    acc  = (start_row + half_line - half_img) * step;
    for (longint unsigned y = start_row; y <= end_row; y++) begin
      ty = acc >> 16;
      if (ty >= th) ty = th - 1;
      acc += step;
      r.out_column     = b.column_x;
      r.row_y          = ROW_W'(y);
      r.texture_select = sel;
      r.texel_x        = TEX_W'(tx);
      r.texel_y        = TEX_W'(ty);
      r.last           = (y == end_row);
      row_q.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count_o < 40) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
    fail_count_o++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : watch
    out_beat_t want;
    if (!rst_ni) begin
      image_height_q   = IH_W'(64);
      texture_width_q  = TW_W'(64);
      texture_height_q = TH_W'(64);
      row_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_IMAGE_HEIGHT:   image_height_q   = cfg_wdata_i[IH_W-1:0];
          REG_TEXTURE_WIDTH:  texture_width_q  = cfg_wdata_i[TW_W-1:0];
          REG_TEXTURE_HEIGHT: texture_height_q = cfg_wdata_i[TH_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (row_q.size() == 0) begin
          report_mismatch("row beat with no column pending", int'(out_data_i.out_column), 0);
        end else begin
          want = row_q.pop_front();
          check_field("out_column", int'(out_data_i.out_column), int'(want.out_column));
          check_field("row_y", int'(out_data_i.row_y), int'(want.row_y));
          check_field("texture_select", int'(out_data_i.texture_select),
                      int'(want.texture_select));
          check_field("texel_x", int'(out_data_i.texel_x), int'(want.texel_x));
          check_field("texel_y", int'(out_data_i.texel_y), int'(want.texel_y));
          check_field("last", int'(out_data_i.last), int'(want.last));
        end
      end
      if (in_valid_i && in_ready_i) plan_column(in_data_i);
    end
    pending_rows_o = row_q.size();
  end

endmodule

// File: dv/textured_wall_column_mapper_test.sv
module textured_wall_column_mapper_test;
  import twcm_pkg::*;

  localparam int     CLK_HALF        = 10;
  localparam int     RESET_CYCLES    = 11;
  localparam int     PHASES          = 9;
  localparam int     PHASE_COLUMNS   = 46;
  localparam int     IDLE_GUARD      = 4;
  localparam int     DRAIN_CYCLES    = 100;
  localparam int     PRESSURE_CYCLES = 250;
  localparam longint LIMIT_TIME      = 700_000_000;

  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;
  localparam logic [SGN_W-1:0]      SIGN_RSVD    = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending_rows;

  textured_wall_column_mapper u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_addr_i  (cfg_addr),
    .cfg_wdata_i (cfg_wdata)
  );

  textured_wall_column_checker u_column_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_rows_o (pending_rows)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_beat_t make_column(input int col, input int lh, input logic side,
                                           input logic [SGN_W-1:0] sx,
                                           input logic [SGN_W-1:0] sy, input int frac);
    in_beat_t b;
    b.column_x    = COL_W'(col);
    b.line_height = LH_W'(lh);
    b.hit_side    = side;
    b.dir_x_sign  = sx;
    b.dir_y_sign  = sy;
    b.wall_frac   = FRAC_W'(frac);
    return b;
  endfunction

  function automatic in_beat_t random_column();
    in_beat_t b;
    int       r;
    b.column_x   = COL_W'($urandom);
    b.hit_side   = 1'($urandom);
    b.dir_x_sign = SGN_W'($urandom_range(0, 3));
    b.dir_y_sign = SGN_W'($urandom_range(0, 3));
    b.wall_frac  = FRAC_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 55) b.line_height = LH_W'($urandom_range(0, 140));
    else if (r < 85) b.line_height = LH_W'($urandom_range(141, 4095));
    else b.line_height = LH_W'($urandom);
    return b;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_reg(input int hi);
    int v;
    case ($urandom_range(0, 5))
      0: v = 1;
      1: v = hi;
      2: v = 0;
      3: v = $urandom_range(0, 511);
      default: v = $urandom_range(1, hi);
    endcase
    return CFG_DATA_W'(v);
  endfunction

  task automatic send_column(input in_beat_t b);
    int gap;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_regs(input logic [CFG_DATA_W-1:0] ih, input logic [CFG_DATA_W-1:0] tw,
                           input logic [CFG_DATA_W-1:0] th);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_IMAGE_HEIGHT;
    cfg_wdata <= ih;
    @(posedge clk);
    cfg_addr  <= REG_TEXTURE_WIDTH;
    cfg_wdata <= tw;
    @(posedge clk);
    cfg_addr  <= REG_TEXTURE_HEIGHT;
    cfg_wdata <= th;
    @(posedge clk);
    cfg_addr  <= REG_UNMAPPED;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_rows != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  initial begin : rx
    int hold;
    int burst;
    int bursts;
    out_ready = 1'b0;
    bursts = 0;
    wait (rst_n === 1'b1);
    forever begin
      // every so often a long hold-off so the column backs up into the input
      hold  = (bursts % 40 == 39) ? PRESSURE_CYCLES : pick_gap();
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      bursts++;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat (burst) @(posedge clk);
    end
  end

  initial begin : stim
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_IMAGE_HEIGHT;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_column(make_column(0, 1, 1'b0, SIGN_POS, SIGN_NEG, 0));
    send_column(make_column(255, 0, 1'b0, SIGN_NEG, SIGN_POS, 'hFFFF));
    send_column(make_column(17, 4095, 1'b0, SIGN_ZERO, SIGN_ZERO, 'h8000));
    send_column(make_column(18, 64, 1'b0, SIGN_RSVD, SIGN_NEG, 'h1234));
    send_column(make_column(19, 63, 1'b1, SIGN_ZERO, SIGN_POS, 'h4321));
    send_column(make_column(20, 2, 1'b1, SIGN_POS, SIGN_NEG, 'hC000));
    send_column(make_column(21, 100, 1'b1, SIGN_NEG, SIGN_ZERO, 'h0FF0));
    send_column(make_column(22, 32, 1'b1, SIGN_NEG, SIGN_RSVD, 'hF00F));
    send_column(make_column(23, 65, 1'b0, SIGN_POS, SIGN_ZERO, 'hFFFF));
    send_column(make_column(24, 128, 1'b0, SIGN_NEG, SIGN_NEG, 1));
    send_column(make_column('hAA, 4094, 1'b1, SIGN_RSVD, SIGN_NEG, 'h5555));
    send_column(make_column('h55, 2048, 1'b0, SIGN_POS, SIGN_POS, 'hAAAA));
    send_column(make_column(25, 3, 1'b1, SIGN_POS, SIGN_POS, 'h7FFF));
    send_column(make_column(26, 127, 1'b0, SIGN_ZERO, SIGN_POS, 'h0001));

    wait_idle();
    load_regs(1, 1, 1);
    send_column(make_column(1, 1, 1'b0, SIGN_POS, SIGN_ZERO, 'hFFFF));
    send_column(make_column(2, 4095, 1'b1, SIGN_ZERO, SIGN_NEG, 0));

    // zero in every register behaves as one
    wait_idle();
    load_regs(0, 0, 0);
    send_column(make_column(3, 0, 1'b1, SIGN_ZERO, SIGN_POS, 'h8001));

    // values above the maxima, image height also wider than its field
    wait_idle();
    load_regs('h1FF, 'h1FF, 'h1FF);
    send_column(make_column(4, 1, 1'b0, SIGN_NEG, SIGN_NEG, 'hFFFF));
    send_column(make_column(5, 4095, 1'b0, SIGN_POS, SIGN_POS, 'hFFFF));
    send_column(make_column(6, 64, 1'b1, SIGN_POS, SIGN_NEG, 'hFFFF));
    send_column(make_column(7, 2, 1'b1, SIGN_POS, SIGN_NEG, 0));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      load_regs(pick_reg(DEF_MAX_IMAGE_HEIGHT), pick_reg(DEF_MAX_TEXTURE_SIZE),
                pick_reg(DEF_MAX_TEXTURE_SIZE));
      for (int k = 0; k < PHASE_COLUMNS; k++) send_column(random_column());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #LIMIT_TIME;
    $display("FAILURE");
    $finish;
  end

endmodule
